>>> rtl/mcpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpi_pkg
// shared types, constants and helpers of the monte carlo pi hit counter
// ----------------------------------------------------------------------------
package mcpi_pkg;

    localparam int LANES       = 4;
    localparam int TOTAL_BITS  = 48;
    localparam int WORD_W      = 64;
    localparam int HALF_W      = WORD_W / 2;
    localparam int FRAC_W      = 52;
    localparam int LO_W        = 32;
    localparam int HI_W        = FRAC_W - LO_W;
    localparam int SQ_W        = 2 * FRAC_W;
    localparam int CNT_W       = $clog2(LANES + 1);
    localparam int LANE_IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int PIPE_STAGES = 5;

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 17;

    localparam logic [WORD_W-1:0] SEED_MULT  = 64'h2545_F491_4F6C_DD1D;
    // 2^(FRAC_W-1): centre of the unit interval in fraction units
    localparam logic [FRAC_W-1:0] HALF_POINT = {1'b1, {(FRAC_W - 1){1'b0}}};
    // 2^(2*(FRAC_W-1)): radius squared in the same units
    localparam logic [SQ_W-1:0]   HIT_LIMIT  = {2'b01, {(SQ_W - 2){1'b0}}};

    typedef logic [WORD_W-1:0]             word_t;
    typedef logic [LANES-1:0]              lane_vec_t;
    typedef logic [LANES-1:0][WORD_W-1:0]  lane_words_t;

    typedef enum logic [2:0] {
        SEED_IDLE,
        SEED_MUL_LL,
        SEED_MUL_HL,
        SEED_MUL_LH,
        SEED_STORE
    } seed_state_t;

    typedef struct packed {
        logic restart;
        logic last_batch;
    } ctrl_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    // seed multipliers C^(k+1), worked out at elaboration
    function automatic lane_words_t build_lane_mults();
        lane_words_t r;
        word_t       v;
        v = 64'd1;
        for (int k = 0; k < LANES; k++)
        begin
            v    = v * SEED_MULT;
            r[k] = v;
        end
        return r;
    endfunction

    localparam lane_words_t LANE_MULT = build_lane_mults();

    // one xorshift step
    function automatic word_t xs_step(word_t s);
        word_t t;
        t = s ^ (s << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

>>> rtl/mcpi_seeder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpi_seeder
// derives the per-lane restart states from the seed with one shared multiplier
// ----------------------------------------------------------------------------
module mcpi_seeder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seed_value_we,
    input  mcpi_pkg::word_t      seed_value,
    output mcpi_pkg::lane_words_t seeded_states,
    output logic                 busy
);
    import mcpi_pkg::*;

    seed_state_t             state_reg, state_next;
    logic [LANE_IDX_W-1:0]   lane_reg, lane_next;
    word_t                   seed_reg;
    word_t                   prod_reg;
    word_t                   acc_reg;
    lane_words_t             seeded_reg;
    word_t                   mult_k;
    logic [HALF_W-1:0]       op_a;
    logic [HALF_W-1:0]       op_b;
    word_t                   product;
    word_t                   store_word;
    logic                    last_lane;

    always_comb
    begin
        mult_k = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (lane_reg == LANE_IDX_W'(k))
                mult_k = LANE_MULT[k];
        end
    end

    // low word of seed * C^(k+1) from three 32x32 partial products
    assign op_a       = (state_reg == SEED_MUL_HL) ? seed_reg[WORD_W-1:HALF_W]
                                                   : seed_reg[HALF_W-1:0];
    assign op_b       = (state_reg == SEED_MUL_LH) ? mult_k[WORD_W-1:HALF_W]
                                                   : mult_k[HALF_W-1:0];
    assign product    = WORD_W'(op_a * op_b);
    assign store_word = acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
    assign last_lane  = (lane_reg == LANE_IDX_W'(LANES - 1));

    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        unique case (state_reg)
            SEED_IDLE:   state_next = SEED_IDLE;
            SEED_MUL_LL: state_next = SEED_MUL_HL;
            SEED_MUL_HL: state_next = SEED_MUL_LH;
            SEED_MUL_LH: state_next = SEED_STORE;
            SEED_STORE:
            begin
                if (last_lane)
                    state_next = SEED_IDLE;
                else
                begin
                    state_next = SEED_MUL_LL;
                    lane_next  = lane_reg + LANE_IDX_W'(1);
                end
            end
            default:     state_next = SEED_IDLE;
        endcase
        if (seed_value_we)
        begin
            state_next = SEED_MUL_LL;
            lane_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEED_IDLE;
            lane_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

    // reset holds the states of the default seed of one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seeded_reg <= LANE_MULT;
        else
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (state_reg == SEED_STORE && lane_reg == LANE_IDX_W'(k))
                    seeded_reg[k] <= store_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seed_value_we)
            seed_reg <= seed_value;
        prod_reg <= product;
        if (state_reg == SEED_MUL_HL)
            acc_reg <= prod_reg;
        else if (state_reg == SEED_MUL_LH)
            acc_reg <= store_word;
    end

    assign seeded_states = seeded_reg;
    assign busy          = (state_reg != SEED_IDLE);

    a_write_starts: assert property (@(posedge clk) disable iff (!rst_n)
        seed_value_we |=> busy)
        else $error("seed write did not start the seeding sequence");

    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (lane_reg <= LANE_IDX_W'(LANES - 1)))
        else $error("seeding lane index out of range");

endmodule

>>> rtl/mcpi_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpi_lane
// one xorshift-plus generator with its pipelined exact circle test
// ----------------------------------------------------------------------------
module mcpi_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  mcpi_pkg::word_t     init_state,
    input  mcpi_pkg::word_t     seed_state,
    input  logic                accept,
    input  logic                restart,
    input  mcpi_pkg::pipe_en_t  en,
    output logic                hit
);
    import mcpi_pkg::*;

    word_t                   state_reg;
    word_t                   s0, s1, s2;
    word_t                   out_x, out_y;
    logic [FRAC_W-1:0]       m_reg, n_reg;
    logic [FRAC_W-1:0]       dx_next, dy_next;
    logic [FRAC_W-1:0]       dx_reg, dy_reg;
    logic [2*LO_W-1:0]       x_ll_reg, y_ll_reg;
    logic [HI_W+LO_W-1:0]    x_hl_reg, y_hl_reg;
    logic [2*HI_W-1:0]       x_hh_reg, y_hh_reg;
    logic [SQ_W-1:0]         sqx_next, sqy_next;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg;
    logic [SQ_W-1:0]         sq_sum;
    logic                    hit_reg;

    // two generator steps per batch
    assign s0    = restart ? seed_state : state_reg;
    assign s1    = xs_step(s0);
    assign s2    = xs_step(s1);
    assign out_x = s0 + s1;
    assign out_y = s1 + s2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= init_state;
        else if (accept)
            state_reg <= s2;
    end

    assign dx_next = (m_reg >= HALF_POINT) ? m_reg - HALF_POINT : HALF_POINT - m_reg;
    assign dy_next = (n_reg >= HALF_POINT) ? n_reg - HALF_POINT : HALF_POINT - n_reg;

    assign sqx_next = {x_hh_reg, {(2*LO_W){1'b0}}}
                    + (SQ_W'(x_hl_reg) << (LO_W + 1))
                    + SQ_W'(x_ll_reg);
    assign sqy_next = {y_hh_reg, {(2*LO_W){1'b0}}}
                    + (SQ_W'(y_hl_reg) << (LO_W + 1))
                    + SQ_W'(y_ll_reg);
    assign sq_sum   = sqx_reg + sqy_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            m_reg <= out_x[FRAC_W-1:0];
            n_reg <= out_y[FRAC_W-1:0];
        end
        if (en.s2)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (en.s3)
        begin
            x_ll_reg <= dx_reg[LO_W-1:0] * dx_reg[LO_W-1:0];
            x_hl_reg <= dx_reg[FRAC_W-1:LO_W] * dx_reg[LO_W-1:0];
            x_hh_reg <= dx_reg[FRAC_W-1:LO_W] * dx_reg[FRAC_W-1:LO_W];
            y_ll_reg <= dy_reg[LO_W-1:0] * dy_reg[LO_W-1:0];
            y_hl_reg <= dy_reg[FRAC_W-1:LO_W] * dy_reg[LO_W-1:0];
            y_hh_reg <= dy_reg[FRAC_W-1:LO_W] * dy_reg[FRAC_W-1:LO_W];
        end
        if (en.s4)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
        if (en.s5)
            hit_reg <= (sq_sum <= HIT_LIMIT);
    end

    assign hit = hit_reg;

endmodule

>>> rtl/mcpi_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpi_merge
// combines the lane hits into mask, batch count and saturating total
// ----------------------------------------------------------------------------
module mcpi_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcpi_pkg::lane_vec_t  hits,
    input  mcpi_pkg::ctrl_t      ctrl,
    input  logic                 fire,
    input  logic                 rsp_stall,
    output logic                 out_ready,
    output logic                 rsp_valid,
    output logic [3:0]           hit_mask,
    output logic [2:0]           batch_hits,
    output logic [mcpi_pkg::TOTAL_BITS-1:0] total_hits,
    output logic                 run_done
);
    import mcpi_pkg::*;

    logic [CNT_W-1:0]        count;
    logic [TOTAL_BITS-1:0]   base;
    logic [TOTAL_BITS:0]     sum;
    logic [TOTAL_BITS-1:0]   total_next;
    logic [TOTAL_BITS-1:0]   total_reg;
    logic [LANES+3:0]        mask_ext;
    logic                    rsp_valid_reg;
    logic [3:0]              mask_reg;
    logic [2:0]              batch_reg;
    logic                    done_reg;

    always_comb
    begin
        count = '0;
        for (int k = 0; k < LANES; k++)
            count = count + CNT_W'(hits[k]);
    end

    assign base       = ctrl.restart ? '0 : total_reg;
    assign sum        = {1'b0, base} + (TOTAL_BITS + 1)'(count);
    assign total_next = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
    assign mask_ext   = {4'b0000, hits};
    assign out_ready  = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (out_ready)
                rsp_valid_reg <= fire;
            if (fire)
                total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mask_reg  <= mask_ext[3:0];
            batch_reg <= 3'(count);
            done_reg  <= ctrl.last_batch;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign hit_mask   = mask_reg;
    assign batch_hits = batch_reg;
    assign total_hits = total_reg;
    assign run_done   = done_reg;

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !ctrl.restart) |-> (total_next >= total_reg))
        else $error("running total fell without a restart");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (count <= CNT_W'(LANES)))
        else $error("batch hit count exceeds lane count");

endmodule

>>> rtl/monte_carlo_pi_hit_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monte_carlo_pi_hit_counter_unit
// four xorshift-plus lanes tossing darts at the unit circle, one batch a beat
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall): one beat runs one batch; restart
//   reseeds every lane from the seed register and clears the running total
//   before the batch, last_batch is echoed as run_done
//   response channel (rsp_valid / rsp_stall): one beat per request beat, in
//   order: hit mask, batch hit count and the saturating running total
//   seed port: seed_value_we writes seed_value; it takes effect at the next
//   restart
// timing
//   pipeline: a beat passes five lane pipeline stages and the output register
//   throughput: one batch per cycle, set by the per-lane pipeline, while the
//   seeder is idle and no stalled response backs up the pipeline; the
//   generator steps twice per lane in the accept cycle
//   a seed write keeps the seeder busy on its single shared 32x32 multiplier
//   for three partial products and a store per lane; req_stall is high then
// reset
//   lanes hold the states of seed one, total is zero, both channels empty
// stall
//   a stalled response holds its beat; stages behind it keep filling any
//   bubbles; back-pressure raises req_stall only once the whole pipeline is full
// ----------------------------------------------------------------------------
module monte_carlo_pi_hit_counter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_value_we,
    input  logic [63:0] seed_value,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        restart,
    input  logic        last_batch,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [3:0]  hit_mask,
    output logic [2:0]  batch_hits,
    output logic [mcpi_pkg::TOTAL_BITS-1:0] total_hits,
    output logic        run_done
);
    import mcpi_pkg::*;

    lane_words_t               seeded_states;
    logic                      seed_busy;
    logic                      accept;
    logic                      out_ready;
    logic                      fire;
    logic [PIPE_STAGES-1:0]    valid_reg;
    logic [PIPE_STAGES-1:0]    stage_ready;
    ctrl_t                     ctrl_reg [PIPE_STAGES];
    ctrl_t                     req_ctrl;
    pipe_en_t                  en;
    lane_vec_t                 hits;

    // seed expansion into per-lane restart states
    mcpi_seeder u_seeder (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_value_we (seed_value_we),
        .seed_value    (seed_value),
        .seeded_states (seeded_states),
        .busy          (seed_busy)
    );

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        stage_ready[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || out_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
    end

    assign en.s1 = stage_ready[0];
    assign en.s2 = stage_ready[1];
    assign en.s3 = stage_ready[2];
    assign en.s4 = stage_ready[3];
    assign en.s5 = stage_ready[4];

    assign req_stall = seed_busy || !stage_ready[0];
    assign accept    = req_valid && !req_stall;
    assign fire      = valid_reg[PIPE_STAGES-1] && out_ready;

    assign req_ctrl.restart    = restart;
    assign req_ctrl.last_batch = last_batch;

    // control travels alongside the lane data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (stage_ready[0])
                valid_reg[0] <= accept;
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                if (stage_ready[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
            ctrl_reg[0] <= req_ctrl;
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            if (stage_ready[i])
                ctrl_reg[i] <= ctrl_reg[i-1];
        end
    end

    // parallel generator lanes
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        mcpi_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .init_state (LANE_MULT[k]),
            .seed_state (seeded_states[k]),
            .accept     (accept),
            .restart    (restart),
            .en         (en),
            .hit        (hits[k])
        );
    end

    // merge of lane results and output register
    mcpi_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .hits       (hits),
        .ctrl       (ctrl_reg[PIPE_STAGES-1]),
        .fire       (fire),
        .rsp_stall  (rsp_stall),
        .out_ready  (out_ready),
        .rsp_valid  (rsp_valid),
        .hit_mask   (hit_mask),
        .batch_hits (batch_hits),
        .total_hits (total_hits),
        .run_done   (run_done)
    );

    a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[PIPE_STAGES-1] && !out_ready) |=> valid_reg[PIPE_STAGES-1])
        else $error("last pipeline stage dropped a batch under back-pressure");

endmodule
